// ===== sv/bsfm_pkg.sv =====
package bsfm_pkg;

    // tick limits
    localparam logic [9:0] MAX_TICK_MS = 10'd500;

    // fault timer limits in ms
    localparam logic [15:0] RANGE_TIMEOUT_MS      = 16'd2000;
    localparam logic [15:0] LOW_PRESS_TIMEOUT_MS  = 16'd4000;
    localparam logic [15:0] OVER_PRESS_TIMEOUT_MS = 16'd3000;
    localparam logic [15:0] SATURATE_TIMEOUT_MS   = 16'd6000;

    // plausible sensor window, Q8.8 cmH2O (-10 and 50)
    localparam logic signed [15:0] SENSOR_MIN_Q88 = -16'sd2560;
    localparam logic signed [15:0] SENSOR_MAX_Q88 = 16'sd12800;

    // therapy modes
    localparam logic [1:0] MODE_OTHER    = 2'd0;
    localparam logic [1:0] MODE_RAMP     = 2'd1;
    localparam logic [1:0] MODE_RUNNING  = 2'd2;
    localparam logic [1:0] MODE_STOPPING = 2'd3;

    // fault kinds
    localparam logic [2:0] FAULT_HEARTBEAT = 3'd0;
    localparam logic [2:0] FAULT_RANGE     = 3'd1;
    localparam logic [2:0] FAULT_LOW_PRESS = 3'd2;
    localparam logic [2:0] FAULT_OVER      = 3'd3;
    localparam logic [2:0] FAULT_SATURATED = 3'd4;

    // register map
    localparam int          CFG_ADDR_W         = 5;
    localparam logic [2:0]  REG_MONITOR_ENABLE = 3'd0;
    localparam logic [2:0]  REG_HB_TIMEOUT     = 3'd1;
    localparam logic [2:0]  REG_HIGH_RPM       = 3'd2;
    localparam logic [2:0]  REG_LOW_PRESS      = 3'd3;
    localparam logic [2:0]  REG_OVER_BAND      = 3'd4;
    localparam logic [2:0]  REG_SAT_BAND       = 3'd5;
    localparam logic [2:0]  REG_SAFE_RPM       = 3'd6;

    typedef struct packed {
        logic [9:0]         tick_ms;
        logic [31:0]        now_ms;
        logic [31:0]        heartbeat_seq;
        logic [1:0]         therapy_mode;
        logic               fault_active;
        logic               grace_active;
        logic signed [15:0] measured_pressure;
        logic signed [15:0] target_pressure;
        logic signed [15:0] sensor_pressure;
        logic [15:0]        blower_rpm;
    } t_in_req;

    typedef struct packed {
        logic        fault_raise;
        logic [2:0]  fault_kind;
        logic [31:0] stale_time_ms;
    } t_out_res;

    typedef struct packed {
        logic               monitor_enable;
        logic [15:0]        heartbeat_timeout_ms;
        logic [15:0]        high_rpm_threshold;
        logic signed [15:0] low_pressure_limit;
        logic [14:0]        overpressure_band;
        logic [14:0]        saturation_band;
        logic [15:0]        safe_rpm_max;
    } t_cfg;

    // heartbeat watchdog status toward the pressure checks
    typedef struct packed {
        logic        tick_ok;
        logic        hb_fault;
        logic [31:0] stale_ms;
    } t_hb_stat;

    // pressure check verdict
    typedef struct packed {
        logic       raise;
        logic [2:0] kind;
    } t_chk_stat;

    // saturating 16-bit timer step
    function automatic logic [15:0] sat_add(input logic [15:0] t, input logic [9:0] dt);
        logic [16:0] s;
        s = {1'b0, t} + {7'b0, dt};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

endpackage

// ===== sv/bsfm_regs.sv =====
module bsfm_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bsfm_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output bsfm_pkg::t_cfg                     o_cfg
);
    import bsfm_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[CFG_ADDR_W-1:2];

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.monitor_enable       <= 1'b1;
            r_cfg.heartbeat_timeout_ms <= 16'd100;
            r_cfg.high_rpm_threshold   <= 16'd12000;
            r_cfg.low_pressure_limit   <= 16'sd384;
            r_cfg.overpressure_band    <= 15'd1280;
            r_cfg.saturation_band      <= 15'd384;
            r_cfg.safe_rpm_max         <= 16'd30000;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MONITOR_ENABLE: r_cfg.monitor_enable       <= pwdata[0];
                REG_HB_TIMEOUT:     r_cfg.heartbeat_timeout_ms <= pwdata[15:0];
                REG_HIGH_RPM:       r_cfg.high_rpm_threshold   <= pwdata[15:0];
                REG_LOW_PRESS:      r_cfg.low_pressure_limit   <= pwdata[15:0];
                REG_OVER_BAND:      r_cfg.overpressure_band    <= pwdata[14:0];
                REG_SAT_BAND:       r_cfg.saturation_band      <= pwdata[14:0];
                REG_SAFE_RPM:       r_cfg.safe_rpm_max         <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (reg_idx)
            REG_MONITOR_ENABLE: prdata = {31'b0, r_cfg.monitor_enable};
            REG_HB_TIMEOUT:     prdata = {16'b0, r_cfg.heartbeat_timeout_ms};
            REG_HIGH_RPM:       prdata = {16'b0, r_cfg.high_rpm_threshold};
            REG_LOW_PRESS:      prdata = {{16{r_cfg.low_pressure_limit[15]}},
                                          r_cfg.low_pressure_limit};
            REG_OVER_BAND:      prdata = {17'b0, r_cfg.overpressure_band};
            REG_SAT_BAND:       prdata = {17'b0, r_cfg.saturation_band};
            REG_SAFE_RPM:       prdata = {16'b0, r_cfg.safe_rpm_max};
            default:            prdata = 32'b0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== sv/bsfm_heartbeat.sv =====
module bsfm_heartbeat (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  bsfm_pkg::t_in_req   i_req,
    input  bsfm_pkg::t_cfg      i_cfg,
    output bsfm_pkg::t_hb_stat  o_hb
);
    import bsfm_pkg::*;

    logic [31:0] r_seen_seq, n_seen_seq;
    logic [31:0] r_last_change, n_last_change;
    logic        r_seen_flag, n_seen_flag;
    logic [31:0] r_stale, n_stale;
    logic        tick_ok;
    logic        hb_fault;
    logic [15:0] limit;
    logic [31:0] elapsed;

    assign tick_ok = (i_req.tick_ms != 10'd0) && (i_req.tick_ms <= MAX_TICK_MS);
    assign limit   = (i_cfg.heartbeat_timeout_ms == 16'd0) ? 16'd1
                                                           : i_cfg.heartbeat_timeout_ms;
    assign elapsed = i_req.now_ms - r_last_change;

    // sequence tracking and staleness
    always_comb begin
        n_seen_seq    = r_seen_seq;
        n_last_change = r_last_change;
        n_seen_flag   = r_seen_flag;
        n_stale       = r_stale;
        hb_fault      = 1'b0;
        if (tick_ok) begin
            if (!r_seen_flag || (i_req.heartbeat_seq != r_seen_seq)) begin
                n_seen_seq    = i_req.heartbeat_seq;
                n_last_change = i_req.now_ms;
                n_seen_flag   = 1'b1;
                n_stale       = 32'd0;
            end else if (i_req.therapy_mode == MODE_OTHER) begin
                n_stale = 32'd0;
            end else begin
                n_stale  = elapsed;
                hb_fault = (elapsed >= {16'b0, limit});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_seq    <= 32'd0;
            r_last_change <= 32'd0;
            r_seen_flag   <= 1'b0;
            r_stale       <= 32'd0;
        end else if (i_fire) begin
            r_seen_seq    <= n_seen_seq;
            r_last_change <= n_last_change;
            r_seen_flag   <= n_seen_flag;
            r_stale       <= n_stale;
        end
    end

    assign o_hb.tick_ok  = tick_ok;
    assign o_hb.hb_fault = hb_fault;
    assign o_hb.stale_ms = n_stale;

endmodule

// ===== sv/bsfm_checks.sv =====
module bsfm_checks (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  bsfm_pkg::t_in_req   i_req,
    input  bsfm_pkg::t_cfg      i_cfg,
    input  bsfm_pkg::t_hb_stat  i_hb,
    output bsfm_pkg::t_chk_stat o_chk
);
    import bsfm_pkg::*;

    logic [15:0] r_range_tmr, n_range_tmr;
    logic [15:0] r_low_tmr, n_low_tmr;
    logic [15:0] r_over_tmr, n_over_tmr;
    logic [15:0] r_sat_tmr, n_sat_tmr;

    logic               run;
    logic               mode_active;
    logic               range_cond;
    logic               low_cond;
    logic               over_cond;
    logic               sat_cond;
    logic signed [17:0] over_limit;
    logic signed [16:0] diff;
    logic [16:0]        diff_abs;
    logic               done;
    logic               raise;
    logic [2:0]         kind;

    assign run = i_hb.tick_ok && i_cfg.monitor_enable && !i_req.fault_active
                 && !i_hb.hb_fault;
    assign mode_active = (i_req.therapy_mode == MODE_RAMP)
                         || (i_req.therapy_mode == MODE_RUNNING);

    // fault conditions
    assign range_cond = (i_req.measured_pressure < SENSOR_MIN_Q88)
                        || (i_req.measured_pressure > SENSOR_MAX_Q88);
    assign low_cond   = (i_req.blower_rpm > i_cfg.high_rpm_threshold)
                        && (i_req.sensor_pressure < i_cfg.low_pressure_limit);
    assign over_limit = $signed({{2{i_req.target_pressure[15]}}, i_req.target_pressure})
                        + $signed({3'b0, i_cfg.overpressure_band});
    assign over_cond  = $signed({{2{i_req.measured_pressure[15]}}, i_req.measured_pressure})
                        > over_limit;
    assign diff       = $signed({i_req.target_pressure[15], i_req.target_pressure})
                        - $signed({i_req.measured_pressure[15], i_req.measured_pressure});
    assign diff_abs   = diff[16] ? 17'(-diff) : 17'(diff);
    assign sat_cond   = (i_req.blower_rpm >= i_cfg.safe_rpm_max)
                        && (diff_abs > {2'b0, i_cfg.saturation_band});

    // timers in priority order, first timeout wins
    always_comb begin
        n_range_tmr = r_range_tmr;
        n_low_tmr   = r_low_tmr;
        n_over_tmr  = r_over_tmr;
        n_sat_tmr   = r_sat_tmr;
        done        = 1'b0;
        raise       = 1'b0;
        kind        = FAULT_HEARTBEAT;
        if (run) begin
            if (!mode_active) begin
                n_range_tmr = 16'd0;
                n_low_tmr   = 16'd0;
                n_over_tmr  = 16'd0;
                n_sat_tmr   = 16'd0;
            end else begin
                if (range_cond) begin
                    n_range_tmr = sat_add(r_range_tmr, i_req.tick_ms);
                    if (n_range_tmr >= RANGE_TIMEOUT_MS) begin
                        done  = 1'b1;
                        raise = 1'b1;
                        kind  = FAULT_RANGE;
                    end
                end else begin
                    n_range_tmr = 16'd0;
                end
                if (!done && i_req.grace_active) begin
                    n_low_tmr  = 16'd0;
                    n_over_tmr = 16'd0;
                    n_sat_tmr  = 16'd0;
                    done       = 1'b1;
                end
                if (!done) begin
                    if (low_cond) begin
                        n_low_tmr = sat_add(r_low_tmr, i_req.tick_ms);
                        if (n_low_tmr >= LOW_PRESS_TIMEOUT_MS) begin
                            done  = 1'b1;
                            raise = 1'b1;
                            kind  = FAULT_LOW_PRESS;
                        end
                    end else begin
                        n_low_tmr = 16'd0;
                    end
                end
                if (!done) begin
                    if (over_cond) begin
                        n_over_tmr = sat_add(r_over_tmr, i_req.tick_ms);
                        if (n_over_tmr >= OVER_PRESS_TIMEOUT_MS) begin
                            done  = 1'b1;
                            raise = 1'b1;
                            kind  = FAULT_OVER;
                        end
                    end else begin
                        n_over_tmr = 16'd0;
                    end
                end
                if (!done) begin
                    if (sat_cond) begin
                        n_sat_tmr = sat_add(r_sat_tmr, i_req.tick_ms);
                        if (n_sat_tmr >= SATURATE_TIMEOUT_MS) begin
                            raise = 1'b1;
                            kind  = FAULT_SATURATED;
                        end
                    end else begin
                        n_sat_tmr = 16'd0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_tmr <= 16'd0;
            r_low_tmr   <= 16'd0;
            r_over_tmr  <= 16'd0;
            r_sat_tmr   <= 16'd0;
        end else if (i_fire) begin
            r_range_tmr <= n_range_tmr;
            r_low_tmr   <= n_low_tmr;
            r_over_tmr  <= n_over_tmr;
            r_sat_tmr   <= n_sat_tmr;
        end
    end

    assign o_chk.raise = raise;
    assign o_chk.kind  = kind;

endmodule

// ===== sv/blower_safety_fault_monitor.sv =====
// Blower safety fault monitor. Each request is one supervisor tick and yields exactly
// one result: whether a fault is raised on this tick, which kind (heartbeat, sensor
// range, low pressure at high rpm, over-pressure, saturated rpm) and the current
// heartbeat stale time in ms. Ticks with tick_ms of 0 or above 500 change no state and
// report the held stale time. A request is registered on entry, evaluated by compare/add logic
// against the watchdog and timer state, and the result is registered on exit; one request per
// cycle is sustained while the result side is not stalled. The result register decouples the
// two sides, so one further request is taken into the input register while a finished result
// still waits. Configuration registers sit at byte addresses 4*i on the APB port and must only
// be written while the block is idle.
module blower_safety_fault_monitor (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  bsfm_pkg::t_in_req                  i_in_req,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output bsfm_pkg::t_out_res                 o_out_res,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bsfm_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import bsfm_pkg::*;

    t_in_req   r_in;
    logic      r_in_vld;
    t_out_res  r_out;
    logic      r_out_vld;
    logic      out_free;
    logic      fire;
    logic      in_take;
    t_cfg      cfg;
    t_hb_stat  hb;
    t_chk_stat chk;

    // handshake
    assign out_free   = !r_out_vld || !i_out_stall;
    assign fire       = r_in_vld && out_free;
    assign o_in_stall = r_in_vld && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    bsfm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bsfm_heartbeat u_hb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_req   (r_in),
        .i_cfg   (cfg),
        .o_hb    (hb)
    );

    bsfm_checks u_chk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_req   (r_in),
        .i_cfg   (cfg),
        .i_hb    (hb),
        .o_chk   (chk)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_req;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out.fault_raise   <= hb.hb_fault || chk.raise;
            r_out.fault_kind    <= hb.hb_fault ? FAULT_HEARTBEAT : chk.kind;
            r_out.stale_time_ms <= hb.stale_ms;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_res   = r_out;

    // a nonzero kind only comes with a raised fault
    a_kind_needs_raise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_res.fault_kind != FAULT_HEARTBEAT) |-> o_out_res.fault_raise)
        else $error("fault kind set without fault raise");

    // kind stays within the defined codes
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_res.fault_kind <= FAULT_SATURATED))
        else $error("fault kind out of range");

    // a held request is not dropped while the result waits
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && r_out_vld && i_out_stall |=> r_in_vld)
        else $error("pending request lost under output stall");

    // no request is evaluated while the input is stalled
    a_no_take_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> !fire)
        else $error("request evaluated while input stalled");

endmodule

// ===== tb/tb_blower_safety_fault_monitor.sv =====
module tb_blower_safety_fault_monitor;
    timeunit 1ns;
    timeprecision 1ps;

    import bsfm_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 300;

    // fault prediction and in-order result checking
    class fault_scoreboard;
        t_cfg        cfg;
        logic [15:0] tmr_range;
        logic [15:0] tmr_low;
        logic [15:0] tmr_over;
        logic [15:0] tmr_sat;
        logic [31:0] last_seq;
        logic [31:0] last_change;
        bit          seq_seen;
        logic [31:0] stale;
        t_out_res    exp_q[$];
        int          errors;

        function new();
            cfg.monitor_enable       = 1'b1;
            cfg.heartbeat_timeout_ms = 16'd100;
            cfg.high_rpm_threshold   = 16'd12000;
            cfg.low_pressure_limit   = 16'sd384;
            cfg.overpressure_band    = 15'd1280;
            cfg.saturation_band      = 15'd384;
            cfg.safe_rpm_max         = 16'd30000;
            clear_timers();
            last_seq    = '0;
            last_change = '0;
            seq_seen    = 1'b0;
            stale       = '0;
            errors      = 0;
        endfunction

        function void clear_timers();
            tmr_range = '0;
            tmr_low   = '0;
            tmr_over  = '0;
            tmr_sat   = '0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_MONITOR_ENABLE: cfg.monitor_enable       = val[0];
                REG_HB_TIMEOUT:     cfg.heartbeat_timeout_ms = val[15:0];
                REG_HIGH_RPM:       cfg.high_rpm_threshold   = val[15:0];
                REG_LOW_PRESS:      cfg.low_pressure_limit   = val[15:0];
                REG_OVER_BAND:      cfg.overpressure_band    = val[14:0];
                REG_SAT_BAND:       cfg.saturation_band      = val[14:0];
                REG_SAFE_RPM:       cfg.safe_rpm_max         = val[15:0];
                default: ;
            endcase
        endfunction

        // saturating ms accumulation
        function logic [15:0] bump(logic [15:0] t, logic [9:0] dt);
            int total;
            total = int'(t) + int'(dt);
            return (total > 65535) ? 16'hFFFF : 16'(total);
        endfunction

        // the four fault timers in priority order; returns 1 when one trips
        function bit run_timers(input t_in_req r, output logic [2:0] kind);
            int meas;
            int tgt;
            int sens;
            int diff;
            meas = $signed(r.measured_pressure);
            tgt  = $signed(r.target_pressure);
            sens = $signed(r.sensor_pressure);
            kind = FAULT_HEARTBEAT;
            if (meas < int'(SENSOR_MIN_Q88) || meas > int'(SENSOR_MAX_Q88)) begin
                tmr_range = bump(tmr_range, r.tick_ms);
                if (tmr_range >= RANGE_TIMEOUT_MS) begin
                    kind = FAULT_RANGE;
                    return 1'b1;
                end
            end else begin
                tmr_range = '0;
            end
            // grace suppresses the remaining checks
            if (r.grace_active) begin
                tmr_low  = '0;
                tmr_over = '0;
                tmr_sat  = '0;
                return 1'b0;
            end
            if (r.blower_rpm > cfg.high_rpm_threshold &&
                sens < int'($signed(cfg.low_pressure_limit))) begin
                tmr_low = bump(tmr_low, r.tick_ms);
                if (tmr_low >= LOW_PRESS_TIMEOUT_MS) begin
                    kind = FAULT_LOW_PRESS;
                    return 1'b1;
                end
            end else begin
                tmr_low = '0;
            end
            if (meas > tgt + int'(cfg.overpressure_band)) begin
                tmr_over = bump(tmr_over, r.tick_ms);
                if (tmr_over >= OVER_PRESS_TIMEOUT_MS) begin
                    kind = FAULT_OVER;
                    return 1'b1;
                end
            end else begin
                tmr_over = '0;
            end
            diff = tgt - meas;
            if (diff < 0) diff = -diff;
            if (r.blower_rpm >= cfg.safe_rpm_max && diff > int'(cfg.saturation_band)) begin
                tmr_sat = bump(tmr_sat, r.tick_ms);
                if (tmr_sat >= SATURATE_TIMEOUT_MS) begin
                    kind = FAULT_SATURATED;
                    return 1'b1;
                end
            end else begin
                tmr_sat = '0;
            end
            return 1'b0;
        endfunction

        // accepted request: advance the watchdog and timers, queue the verdict
        function void note_request(t_in_req r);
            t_out_res    res;
            logic        hb_fire;
            logic [31:0] limit;
            logic [2:0]  kind;
            res     = '0;
            hb_fire = 1'b0;
            if (r.tick_ms != 10'd0 && r.tick_ms <= MAX_TICK_MS) begin
                if (!seq_seen || r.heartbeat_seq != last_seq) begin
                    last_seq    = r.heartbeat_seq;
                    last_change = r.now_ms;
                    seq_seen    = 1'b1;
                    stale       = '0;
                end else if (r.therapy_mode == MODE_OTHER) begin
                    stale = '0;
                end else begin
                    limit = (cfg.heartbeat_timeout_ms == 16'd0) ?
                            32'd1 : 32'(cfg.heartbeat_timeout_ms);
                    stale = r.now_ms - last_change;
                    if (stale >= limit) begin
                        hb_fire         = 1'b1;
                        res.fault_raise = 1'b1;
                        res.fault_kind  = FAULT_HEARTBEAT;
                    end
                end
                if (cfg.monitor_enable && !r.fault_active && !hb_fire) begin
                    if (r.therapy_mode != MODE_RAMP && r.therapy_mode != MODE_RUNNING) begin
                        clear_timers();
                    end else if (run_timers(r, kind)) begin
                        res.fault_raise = 1'b1;
                        res.fault_kind  = kind;
                    end
                end
            end
            res.stale_time_ms = stale;
            exp_q.push_back(res);
        endfunction

        function void flag(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_out_res got);
            t_out_res want;
            if (exp_q.size() == 0) begin
                $display("%0t: result with nothing expected, expected none actual %0h",
                         $time, got);
                errors++;
                return;
            end
            want = exp_q.pop_front();
            flag("fault_raise", 32'(want.fault_raise), 32'(got.fault_raise));
            flag("fault_kind", 32'(want.fault_kind), 32'(got.fault_kind));
            flag("stale_time_ms", want.stale_time_ms, got.stale_time_ms);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_req               i_in_req = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_res              o_out_res;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    fault_scoreboard sb;
    logic [31:0]     clock_ms;
    logic [31:0]     hb_seq;
    int              flavor;
    bit              flavor_lock;
    bit              idle_on;
    bit              hold_req;
    int              cycle_cnt;

    blower_safety_fault_monitor u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_res   (o_out_res),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // observe both handshakes
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) sb.note_request(i_in_req);
            if (o_out_valid && !i_out_stall) sb.check_result(o_out_res);
        end
    end

    // result side back-pressure: long hold-off on demand, short random bursts while idling is on
    initial begin
        int span;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 6) == 0) begin
                span = $urandom_range(1, 15);
                i_out_stall <= 1'b1;
                repeat (span) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // run limit
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic signed [15:0] clamp16(int v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return 16'(v);
    endfunction

    // quiet tick in the plausible window
    function automatic t_in_req calm_req(logic [9:0] dt, logic [31:0] now,
                                         logic [31:0] seq, logic [1:0] mode);
        t_in_req r;
        r                   = '0;
        r.tick_ms           = dt;
        r.now_ms            = now;
        r.heartbeat_seq     = seq;
        r.therapy_mode      = mode;
        r.measured_pressure = 16'sd2560;
        r.target_pressure   = 16'sd2560;
        r.sensor_pressure   = 16'sd2560;
        r.blower_rpm        = 16'd8000;
        return r;
    endfunction

    // random tick; the current flavor keeps one fault condition alive across ticks
    function automatic t_in_req next_tick();
        t_in_req      r;
        logic [159:0] bits;
        int           tgt;
        int           meas;
        int           sens;
        int           rpm;
        int           pick;
        int           thr;
        int           low;
        if (!flavor_lock && $urandom_range(0, 9) == 0) flavor = $urandom_range(0, 4);
        // noise request, every field random
        if (!flavor_lock && $urandom_range(0, 11) == 0) begin
            bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
            r = bits[$bits(t_in_req)-1:0];
            return r;
        end
        if (flavor_lock)
            r.tick_ms = 10'($urandom_range(450, 500));
        else if ($urandom_range(0, 15) == 0)
            r.tick_ms = $urandom_range(0, 1) ? 10'd0 : 10'($urandom_range(501, 1023));
        else if ($urandom_range(0, 1))
            r.tick_ms = 10'($urandom_range(300, 500));
        else
            r.tick_ms = 10'($urandom_range(1, 500));
        clock_ms = clock_ms + 32'(r.tick_ms);
        if ($urandom_range(0, 49) == 0) clock_ms = $urandom;
        r.now_ms = clock_ms;
        if (flavor_lock || $urandom_range(0, 3) != 0)
            hb_seq = ($urandom_range(0, 3) == 0) ? 32'($urandom) : hb_seq + 32'd1;
        r.heartbeat_seq = hb_seq;
        pick = $urandom_range(0, 9);
        if (flavor_lock)
            r.therapy_mode = $urandom_range(0, 1) ? MODE_RAMP : MODE_RUNNING;
        else if (pick < 4)
            r.therapy_mode = MODE_RAMP;
        else if (pick < 8)
            r.therapy_mode = MODE_RUNNING;
        else if (pick == 8)
            r.therapy_mode = MODE_OTHER;
        else
            r.therapy_mode = MODE_STOPPING;
        r.fault_active = !flavor_lock && ($urandom_range(0, 9) == 0);
        r.grace_active = !flavor_lock && ($urandom_range(0, 7) == 0);
        tgt  = $urandom_range(0, 5120);
        meas = tgt + int'($urandom_range(0, 400)) - 200;
        sens = $urandom_range(256, 5120);
        rpm  = $urandom_range(0, 40000);
        thr  = int'(sb.cfg.high_rpm_threshold);
        low  = int'($signed(sb.cfg.low_pressure_limit));
        case (flavor)
            1: meas = $urandom_range(0, 1) ? -int'($urandom_range(2561, 32768)) :
                                              int'($urandom_range(12801, 32767));
            2: begin
                if (thr < 65535) rpm = $urandom_range(thr + 1, 65535);
                if (low > -32768) sens = -32768 + int'($urandom_range(0, low + 32767));
            end
            3: meas = tgt + int'(sb.cfg.overpressure_band) + int'($urandom_range(1, 400));
            4: begin
                rpm  = $urandom_range(int'(sb.cfg.safe_rpm_max), 65535);
                pick = int'(sb.cfg.saturation_band) + int'($urandom_range(1, 400));
                meas = $urandom_range(0, 1) ? tgt + pick : tgt - pick;
            end
            default: ;
        endcase
        r.measured_pressure = clamp16(meas);
        r.target_pressure   = clamp16(tgt);
        r.sensor_pressure   = clamp16(sens);
        r.blower_rpm        = 16'(rpm);
        return r;
    endfunction

    // offer one request and hold it until taken
    task automatic send_req(input t_in_req r);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 15);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++) send_req(next_tick());
    endtask

    // stop offering and wait until every result is back
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.exp_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // apb write: setup then access
    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    initial begin
        t_in_req r;
        sb          = new();
        clock_ms    = $urandom;
        hb_seq      = $urandom;
        flavor      = 0;
        flavor_lock = 1'b0;
        idle_on     = 1'b1;
        hold_req    = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // heartbeat watchdog at reset values
        r = calm_req(10'd1, 32'd1000, 32'd5, MODE_RUNNING);
        send_req(r);
        r.now_ms = 32'd1040; r.therapy_mode = MODE_OTHER;
        send_req(r);
        r.now_ms = 32'd1090; r.therapy_mode = MODE_RAMP;
        send_req(r);
        r.now_ms = 32'd1100; r.therapy_mode = MODE_STOPPING;
        send_req(r);
        r.now_ms = 32'd1300; r.fault_active = 1'b1;
        send_req(r);
        // clock wrapped below the last change
        r.now_ms = 32'd20;
        send_req(r);
        // ignored ticks
        r.tick_ms = 10'd0;
        send_req(r);
        r.tick_ms = 10'd501;
        send_req(r);
        r.tick_ms = 10'h3FF;
        send_req(r);

        // sensor range at full scale, fresh sequence every tick
        r = calm_req(10'd500, 32'hFFFF_FE00, 32'hFFFF_FFFF, MODE_RAMP);
        for (int k = 0; k < 4; k++) begin
            r.measured_pressure = k[0] ? 16'sh7FFF : 16'sh8000;
            r.heartbeat_seq     = r.heartbeat_seq - 32'd1;
            r.now_ms            = r.now_ms + 32'd500;
            send_req(r);
        end
        // grace at window edge with every other check provoked
        r.grace_active      = 1'b1;
        r.measured_pressure = SENSOR_MAX_Q88;
        r.target_pressure   = 16'sh8000;
        r.sensor_pressure   = 16'sh8000;
        r.blower_rpm        = 16'hFFFF;
        r.heartbeat_seq     = 32'd0;
        send_req(r);
        // low pressure, over-pressure and saturation counting together
        r.grace_active      = 1'b0;
        r.measured_pressure = SENSOR_MIN_Q88;
        for (int k = 0; k < 3; k++) begin
            r.heartbeat_seq = r.heartbeat_seq + 32'd1;
            r.therapy_mode  = k[0] ? MODE_RUNNING : MODE_RAMP;
            send_req(r);
        end
        r.heartbeat_seq = 32'h8000_0000;
        r.therapy_mode  = MODE_STOPPING;
        send_req(r);
        r.heartbeat_seq   = 32'h7FFF_FFFF;
        r.therapy_mode    = MODE_RUNNING;
        r.blower_rpm      = 16'd0;
        r.target_pressure = 16'sh7FFF;
        send_req(r);

        run_random(120);

        // low extremes, checks disabled
        settle();
        cfg_write(REG_MONITOR_ENABLE, 32'd0);
        cfg_write(REG_HB_TIMEOUT, 32'd0);
        cfg_write(REG_HIGH_RPM, 32'd0);
        cfg_write(REG_LOW_PRESS, 32'h0000_8000);
        cfg_write(REG_OVER_BAND, 32'd0);
        cfg_write(REG_SAT_BAND, 32'd0);
        cfg_write(REG_SAFE_RPM, 32'd0);
        run_random(60);

        // high extremes
        settle();
        cfg_write(REG_MONITOR_ENABLE, 32'd1);
        cfg_write(REG_HB_TIMEOUT, 32'd65535);
        cfg_write(REG_HIGH_RPM, 32'd65535);
        cfg_write(REG_LOW_PRESS, 32'h0000_7FFF);
        cfg_write(REG_OVER_BAND, 32'd32767);
        cfg_write(REG_SAT_BAND, 32'd32767);
        cfg_write(REG_SAFE_RPM, 32'd65535);
        run_random(60);

        // moderate limits; a long out-of-range stretch drives the timer to saturation
        settle();
        cfg_write(REG_HB_TIMEOUT, 32'd2000);
        cfg_write(REG_HIGH_RPM, 32'd10000);
        cfg_write(REG_LOW_PRESS, 32'd512);
        cfg_write(REG_OVER_BAND, 32'd256);
        cfg_write(REG_SAT_BAND, 32'd256);
        cfg_write(REG_SAFE_RPM, 32'd20000);
        flavor      = 1;
        flavor_lock = 1'b1;
        run_random(150);
        flavor_lock = 1'b0;
        // result side held off while requests keep coming
        hold_req = 1'b1;
        run_random(40);
        settle();
        run_random(110);

        // random limits, no idling to the end
        settle();
        cfg_write(REG_HB_TIMEOUT, 32'($urandom_range(50, 3000)));
        cfg_write(REG_HIGH_RPM, 32'($urandom_range(0, 65535)));
        cfg_write(REG_LOW_PRESS, 32'($urandom_range(0, 65535)));
        cfg_write(REG_OVER_BAND, 32'($urandom_range(0, 32767)));
        cfg_write(REG_SAT_BAND, 32'($urandom_range(0, 32767)));
        cfg_write(REG_SAFE_RPM, 32'($urandom_range(0, 65535)));
        idle_on = 1'b0;
        run_random(100);

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.exp_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
